@@ rtl/kstm_pkg.sv @@
// ============================================================================
// kstm_pkg: shared types and constants for the key template matcher
// Profile tables, field widths, sequencer states and control bundles.
// ============================================================================
package kstm_pkg;

    localparam int ACC_WIDTH_DEF = 32;
    localparam int N_PC          = 12;
    localparam int PC_W          = 4;
    localparam int MAG_W         = 16;
    // profile entries are below 1024, profile sums below 8192
    localparam int PROF_W        = 10;
    localparam int GROUP_GROW    = PROF_W + 2;
    localparam int SCORE_GROW    = PROF_W + 3;

    localparam logic [PC_W-1:0] LAST_ROOT = PC_W'(N_PC - 1);

    localparam logic [PROF_W-1:0] MAJOR_PROF [N_PC] = '{
        10'd635, 10'd223, 10'd348, 10'd233, 10'd438, 10'd409,
        10'd252, 10'd519, 10'd239, 10'd366, 10'd229, 10'd288
    };
    localparam logic [PROF_W-1:0] MINOR_PROF [N_PC] = '{
        10'd633, 10'd268, 10'd352, 10'd538, 10'd260, 10'd353,
        10'd254, 10'd475, 10'd398, 10'd269, 10'd334, 10'd317
    };

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ROT   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    // per-cycle command to every cell of the ring
    typedef struct packed {
        logic add;
        logic rotate;
        logic clear;
    } t_cell_ctl;

    // rotation step travelling alongside the scores
    typedef struct packed {
        logic            vld;
        logic [PC_W-1:0] root;
    } t_tag;

    typedef struct packed {
        logic [PC_W-1:0] root;
        logic            minor;
    } t_key_res;

endpackage

@@ rtl/musical_key_template_match_core.sv @@
// ============================================================================
// musical_key_template_match_core: chroma key finder by profile matching
// Accumulates pitch-tagged magnitudes into twelve bins and, on the last
// request of a batch, scores 24 rotated key profiles and reports the best.
// ============================================================================
//
//  channel   | dir | payload                                  | handshake
//  ----------+-----+------------------------------------------+----------------
//  s_axis    | in  | tdata[3:0] pitch_class, [19:4] magnitude,| tvalid / tready
//            |     | tlast = last                             |
//  m_axis    | out | tdata[3:0] key_root, [4] is_minor,       | tvalid / tready
//            |     | [5] key_known                            |
//
//  Requests without tlast stream back to back while the core is idle.
//  A request with tlast holds the input while the ring turns once per root,
//  the scores pass the product, group-sum, score-sum and best/done
//  registers, and the result loads the output register.
//  Output back-pressure holds the emit state only while a previous result still waits.
//  Reset (synchronous, active low) clears the bins, sequencer and output valid.
//
module musical_key_template_match_core import kstm_pkg::*; #(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [3:0] pitch_class, [19:4] magnitude
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [3:0] key_root, [4] is_minor, [5] key_known
);

    localparam int PW = ACC_WIDTH + PROF_W;

    t_state                r_state, n_state;
    logic [PC_W-1:0]       r_step, n_step;
    logic                  r_known, n_known;
    logic                  r_m_vld, n_m_vld;
    t_key_res              r_key, n_key;
    logic                  r_key_known, n_key_known;

    t_cell_ctl             w_ctl;
    t_tag                  w_tag;
    t_key_res              w_best;
    logic                  w_done;
    logic                  w_accept;
    logic                  w_any_bin;
    logic [PC_W-1:0]       w_pitch_class;
    logic [MAG_W-1:0]      w_magnitude;
    logic [ACC_WIDTH-1:0]  w_bin      [N_PC];
    logic [PW-1:0]         w_prod_maj [N_PC];
    logic [PW-1:0]         w_prod_min [N_PC];

    assign w_pitch_class = s_axis_tdata[PC_W-1:0];
    assign w_magnitude   = s_axis_tdata[PC_W+MAG_W-1:PC_W];
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // ring control: add while idle, rotate on every turn but the last, clear on the last turn
    always_comb begin
        w_ctl.add    = w_accept;
        w_ctl.rotate = (r_state == S_ROT) && (r_step != LAST_ROOT);
        w_ctl.clear  = (r_state == S_ROT) && (r_step == LAST_ROOT);
        w_tag.vld    = (r_state == S_ROT);
        w_tag.root   = r_step;
    end

    // cell i takes its bin from cell i+1, so at step r it holds bin (i+r) mod 12
    for (genvar gi = 0; gi < N_PC; gi++) begin : g_cell
        kstm_cell #(
            .ACC_WIDTH (ACC_WIDTH),
            .IDX       (gi)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_pitch_class (w_pitch_class),
            .i_magnitude   (w_magnitude),
            .i_nbr_bin     (w_bin[(gi + 1) % N_PC]),
            .o_bin         (w_bin[gi]),
            .o_prod_maj    (w_prod_maj[gi]),
            .o_prod_min    (w_prod_min[gi])
        );
    end

    kstm_score #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_score (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (w_tag),
        .i_prod_maj (w_prod_maj),
        .i_prod_min (w_prod_min),
        .o_best     (w_best),
        .o_done     (w_done)
    );

    always_comb begin
        w_any_bin = 1'b0;
        for (int i = 0; i < N_PC; i++) begin
            w_any_bin = w_any_bin | (|w_bin[i]);
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_known     = r_known;
        n_m_vld     = r_m_vld;
        n_key       = r_key;
        n_key_known = r_key_known;
        if (r_m_vld && m_axis_tready) begin
            n_m_vld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (w_accept && s_axis_tlast) begin
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                // bins still hold the batch totals on the first turn
                if (r_step == '0) begin
                    n_known = w_any_bin;
                end
                if (r_step == LAST_ROOT) begin
                    n_state = S_DRAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DRAIN: begin
                if (w_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_m_vld || m_axis_tready) begin
                    n_m_vld     = 1'b1;
                    n_key       = w_best;
                    n_key_known = r_known;
                    if (!r_known) begin
                        n_key = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_m_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_m_vld <= n_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_known     <= n_known;
        r_key       <= n_key;
        r_key_known <= n_key_known;
    end

    assign m_axis_tvalid = r_m_vld;
    assign m_axis_tdata  = {2'b00, r_key_known, r_key.minor, r_key.root};

`ifndef ASSERT_OFF
    // the score pipeline finishes only while the sequencer waits for it
    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_DRAIN))
        else $error("score completion outside drain");

    // the ring is empty once the rotation ends
    a_bins_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && $past(r_state == S_ROT)) |-> !w_any_bin)
        else $error("chroma bins not cleared after evaluation");

    // a new result appears only from the emit state
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_vld) |-> $past(r_state == S_EMIT))
        else $error("result raised outside emit");

    // an unknown key reports root 0, major
    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_vld && !r_key_known) |-> (r_key.root == '0 && !r_key.minor))
        else $error("unknown key with non-zero root or mode");
`endif

endmodule

@@ rtl/kstm_cell.sv @@
// ============================================================================
// kstm_cell: one chroma bin of the rotating ring
// Saturating accumulate, hand-over to the neighbour, profile products.
// ============================================================================
module kstm_cell import kstm_pkg::*; #(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF,
    parameter int IDX       = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cell_ctl                   i_ctl,
    input  logic [PC_W-1:0]             i_pitch_class,
    input  logic [MAG_W-1:0]            i_magnitude,
    input  logic [ACC_WIDTH-1:0]        i_nbr_bin,
    output logic [ACC_WIDTH-1:0]        o_bin,
    output logic [ACC_WIDTH+PROF_W-1:0] o_prod_maj,
    output logic [ACC_WIDTH+PROF_W-1:0] o_prod_min
);

    localparam int PW = ACC_WIDTH + PROF_W;

    logic [ACC_WIDTH-1:0] r_bin, n_bin;
    logic [ACC_WIDTH:0]   w_sum;
    logic [PW-1:0]        r_prod_maj, r_prod_min;

    assign w_sum = {1'b0, r_bin} + (ACC_WIDTH + 1)'(i_magnitude);

    always_comb begin
        n_bin = r_bin;
        priority if (i_ctl.clear) begin
            n_bin = '0;
        end else if (i_ctl.rotate) begin
            n_bin = i_nbr_bin;
        end else if (i_ctl.add && i_pitch_class == PC_W'(IDX)) begin
            // saturate on carry out
            n_bin = w_sum[ACC_WIDTH] ? '1 : w_sum[ACC_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin <= '0;
        end else begin
            r_bin <= n_bin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_maj <= PW'(r_bin) * PW'(MAJOR_PROF[IDX]);
        r_prod_min <= PW'(r_bin) * PW'(MINOR_PROF[IDX]);
    end

    assign o_bin      = r_bin;
    assign o_prod_maj = r_prod_maj;
    assign o_prod_min = r_prod_min;

endmodule

@@ rtl/kstm_score.sv @@
// ============================================================================
// kstm_score: score summation and best-key tracking
// Registered adder tree over the ring's products, then ordered argmax.
// ============================================================================
module kstm_score import kstm_pkg::*; #(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_tag                        i_tag,
    input  logic [ACC_WIDTH+PROF_W-1:0] i_prod_maj [N_PC],
    input  logic [ACC_WIDTH+PROF_W-1:0] i_prod_min [N_PC],
    output t_key_res                    o_best,
    output logic                        o_done
);

    localparam int GW    = ACC_WIDTH + GROUP_GROW;
    localparam int SW    = ACC_WIDTH + SCORE_GROW;
    localparam int N_GRP = N_PC / 4;

    t_tag          r_a_tag, r_b_tag, r_c_tag;
    logic [GW-1:0] w_grp_maj [N_GRP];
    logic [GW-1:0] w_grp_min [N_GRP];
    logic [GW-1:0] r_grp_maj [N_GRP];
    logic [GW-1:0] r_grp_min [N_GRP];
    logic [SW-1:0] r_c_maj, r_c_min;
    logic [SW-1:0] r_best, n_best;
    t_key_res      r_best_key, n_best_key;
    logic          r_done;
    logic          w_take_maj, w_min_gt_best, w_min_gt_maj, w_take_min;

    // tags follow the data one stage at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
            r_b_tag <= '0;
            r_c_tag <= '0;
            r_done  <= 1'b0;
        end else begin
            r_a_tag <= i_tag;
            r_b_tag <= r_a_tag;
            r_c_tag <= r_b_tag;
            r_done  <= r_c_tag.vld && (r_c_tag.root == LAST_ROOT);
        end
    end

    // groups of four products
    always_comb begin
        for (int g = 0; g < N_GRP; g++) begin
            w_grp_maj[g] = GW'(i_prod_maj[4*g]) + GW'(i_prod_maj[4*g+1])
                         + GW'(i_prod_maj[4*g+2]) + GW'(i_prod_maj[4*g+3]);
            w_grp_min[g] = GW'(i_prod_min[4*g]) + GW'(i_prod_min[4*g+1])
                         + GW'(i_prod_min[4*g+2]) + GW'(i_prod_min[4*g+3]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_maj <= w_grp_maj;
        r_grp_min <= w_grp_min;
        r_c_maj   <= SW'(r_grp_maj[0]) + SW'(r_grp_maj[1]) + SW'(r_grp_maj[2]);
        r_c_min   <= SW'(r_grp_min[0]) + SW'(r_grp_min[1]) + SW'(r_grp_min[2]);
    end

    // major before minor; root 0 always loads, then strictly greater replaces
    assign w_take_maj    = (r_c_tag.root == '0) || (r_c_maj > r_best);
    assign w_min_gt_best = r_c_min > r_best;
    assign w_min_gt_maj  = r_c_min > r_c_maj;
    assign w_take_min    = w_take_maj ? w_min_gt_maj : w_min_gt_best;

    always_comb begin
        n_best     = r_best;
        n_best_key = r_best_key;
        if (r_c_tag.vld) begin
            if (w_take_min) begin
                n_best           = r_c_min;
                n_best_key.root  = r_c_tag.root;
                n_best_key.minor = 1'b1;
            end else if (w_take_maj) begin
                n_best           = r_c_maj;
                n_best_key.root  = r_c_tag.root;
                n_best_key.minor = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best     <= n_best;
        r_best_key <= n_best_key;
    end

    assign o_best = r_best_key;
    assign o_done = r_done;

endmodule
